// ===== hdl/sac_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sac_pkg
// Shared constants, case codes and the side-band tag type of the
// shortest-arc quaternion pipeline.
// ============================================================================
package sac_pkg;

    localparam int FRAC_BITS_DEF = 14;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int THR_W  = 15;
    localparam int CASE_W = 2;

    localparam logic [THR_W-1:0] THR_RESET = 15'd16382;

    // Every root in the pipeline is taken from a radicand of this width.
    // It holds (1 + d) << (FRAC_BITS - 1) for FRAC_BITS up to 30 as well as
    // the squared axis length shifted up by LEN_SHIFT.
    localparam int SQRT_RAD_W = 64;
    localparam int LEN_W      = 32;
    localparam int LEN_SHIFT  = 32;
    localparam int NUM_SHIFT  = 16;

    localparam int FRONT_STAGES = 3;

    typedef enum logic [CASE_W-1:0] {
        CASE_GENERAL  = 2'd0,
        CASE_ALIGNED  = 2'd1,
        CASE_INVERTED = 2'd2
    } t_case;

    typedef struct packed {
        t_case             kind;
        logic [IN_W-1:0]   ax;
        logic [IN_W-1:0]   az;
        logic              neg_x;
        logic              neg_z;
        logic              axis_zero;
    } t_front_tag;

endpackage

// ===== hdl/sac_in_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sac_in_if
// Valid/ready channel that carries one surface normal per transfer.
// ============================================================================
interface sac_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [sac_pkg::IN_W-1:0]  normal_x;
    logic signed [sac_pkg::IN_W-1:0]  normal_y;
    logic signed [sac_pkg::IN_W-1:0]  normal_z;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    output ready);
endinterface

// ===== hdl/sac_out_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sac_out_if
// Valid/ready channel that carries one quaternion and its case code per
// transfer.
// ============================================================================
interface sac_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [sac_pkg::OUT_W-1:0]  quat_w;
    logic signed [sac_pkg::OUT_W-1:0]  quat_x;
    logic signed [sac_pkg::OUT_W-1:0]  quat_y;
    logic signed [sac_pkg::OUT_W-1:0]  quat_z;
    logic [sac_pkg::CASE_W-1:0]        case_taken;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, output case_taken, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, input case_taken, output ready);
endinterface

// ===== hdl/sac_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sac_front
// Three pipeline stages: clamp and classify the normal, square the axis
// components, then form the three radicands for the root pipeline.
// ============================================================================
module sac_front #(
    parameter int FRAC_BITS = sac_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic [sac_pkg::FRONT_STAGES-1:0]     i_en,
    input  logic signed [sac_pkg::IN_W-1:0]      i_nx,
    input  logic signed [sac_pkg::IN_W-1:0]      i_ny,
    input  logic signed [sac_pkg::IN_W-1:0]      i_nz,
    input  logic [sac_pkg::THR_W-1:0]            i_thr,
    output logic [sac_pkg::SQRT_RAD_W-1:0]       o_rad_w,
    output logic [sac_pkg::SQRT_RAD_W-1:0]       o_rad_s,
    output logic [sac_pkg::SQRT_RAD_W-1:0]       o_rad_len,
    output sac_pkg::t_front_tag                  o_tag
);

    localparam int IW  = sac_pkg::IN_W;
    localparam int DW  = (FRAC_BITS + 2 > IW + 1) ? FRAC_BITS + 2 : IW + 1;
    localparam int AW  = FRAC_BITS + 2;
    localparam int SQW = 2 * IW;
    localparam int RW  = sac_pkg::SQRT_RAD_W;
    localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

    function automatic logic [IW-1:0] mag(input logic signed [IW-1:0] v);
        logic signed [IW:0] e;
        e = {v[IW-1], v};
        if (e < 0) begin
            e = -e;
        end
        return e[IW-1:0];
    endfunction

    logic signed [DW-1:0] w_ny;
    logic signed [DW-1:0] w_thr;
    logic signed [DW-1:0] w_d;
    logic signed [DW-1:0] w_sum_a;
    logic signed [DW-1:0] w_sum_b;

    logic [AW-1:0]        n_a0, n_b0;
    sac_pkg::t_front_tag  n_tag0;
    logic [SQW-1:0]       n_sqx1, n_sqz1;
    logic [SQW-1:0]       w_l2;
    logic [RW-1:0]        n_rad_w2, n_rad_s2, n_rad_len2;

    logic [AW-1:0]        r_a0, r_b0, r_a1, r_b1;
    sac_pkg::t_front_tag  r_tag0, r_tag1, r_tag2;
    logic [SQW-1:0]       r_sqx1, r_sqz1;
    logic [RW-1:0]        r_rad_w2, r_rad_s2, r_rad_len2;

    assign w_ny  = $signed({{(DW-IW){i_ny[IW-1]}}, i_ny});
    assign w_thr = $signed({{(DW-sac_pkg::THR_W){1'b0}}, i_thr});

    always_comb begin
        w_d = w_ny;
        if (w_ny > ONE) begin
            w_d = ONE;
        end else if (w_ny < -ONE) begin
            w_d = -ONE;
        end

        if (w_d > w_thr) begin
            n_tag0.kind = sac_pkg::CASE_ALIGNED;
        end else if (w_d < -w_thr) begin
            n_tag0.kind = sac_pkg::CASE_INVERTED;
        end else begin
            n_tag0.kind = sac_pkg::CASE_GENERAL;
        end

        w_sum_a = ONE + w_d;
        w_sum_b = ONE - w_d;
        n_a0    = w_sum_a[AW-1:0];
        n_b0    = w_sum_b[AW-1:0];

        n_tag0.ax        = mag(i_nx);
        n_tag0.az        = mag(i_nz);
        // The x part takes the sign of nz, the z part the sign of -nx.
        n_tag0.neg_x     = i_nz[IW-1];
        n_tag0.neg_z     = !i_nx[IW-1] && (i_nx != '0);
        n_tag0.axis_zero = (i_nx == '0) && (i_nz == '0);
    end

    always_comb begin
        n_sqx1     = SQW'(r_tag0.ax) * SQW'(r_tag0.ax);
        n_sqz1     = SQW'(r_tag0.az) * SQW'(r_tag0.az);
        w_l2       = r_sqx1 + r_sqz1;
        n_rad_len2 = {w_l2, {sac_pkg::LEN_SHIFT{1'b0}}};
        n_rad_w2   = RW'(r_a1) << (FRAC_BITS - 1);
        n_rad_s2   = RW'(r_b1) << (FRAC_BITS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a0   <= n_a0;
            r_b0   <= n_b0;
            r_tag0 <= n_tag0;
        end
        if (i_en[1]) begin
            r_a1   <= r_a0;
            r_b1   <= r_b0;
            r_sqx1 <= n_sqx1;
            r_sqz1 <= n_sqz1;
            r_tag1 <= r_tag0;
        end
        if (i_en[2]) begin
            r_rad_w2   <= n_rad_w2;
            r_rad_s2   <= n_rad_s2;
            r_rad_len2 <= n_rad_len2;
            r_tag2     <= r_tag1;
        end
    end

    assign o_rad_w   = r_rad_w2;
    assign o_rad_s   = r_rad_s2;
    assign o_rad_len = r_rad_len2;
    assign o_tag     = r_tag2;

endmodule

// ===== hdl/sac_isqrt_pipe.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sac_isqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage,
// over several lanes that move together with a side-band tag.
// ============================================================================
module sac_isqrt_pipe #(
    parameter int LANES = 3
) (
    input  logic                              i_clk,
    input  logic [sac_pkg::SQRT_RAD_W/2-1:0]  i_en,
    input  logic [sac_pkg::SQRT_RAD_W-1:0]    i_rad [LANES],
    input  sac_pkg::t_front_tag               i_tag,
    output logic [sac_pkg::SQRT_RAD_W/2-1:0]  o_root [LANES],
    output sac_pkg::t_front_tag               o_tag
);

    localparam int RAD_W = sac_pkg::SQRT_RAD_W;
    localparam int RT_W  = RAD_W / 2;
    localparam int REM_W = RT_W + 3;

    logic [RAD_W-1:0]    r_rad  [LANES][RT_W];
    logic [REM_W-1:0]    r_rem  [LANES][RT_W];
    logic [RT_W-1:0]     r_root [LANES][RT_W];
    sac_pkg::t_front_tag r_tag  [RT_W];

    logic [RAD_W-1:0]    n_rad  [LANES][RT_W];
    logic [REM_W-1:0]    n_rem  [LANES][RT_W];
    logic [RT_W-1:0]     n_root [LANES][RT_W];

    always_comb begin
        logic [RAD_W-1:0] p_rad;
        logic [REM_W-1:0] p_rem;
        logic [RT_W-1:0]  p_root;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        for (int l = 0; l < LANES; l++) begin
            for (int j = 0; j < RT_W; j++) begin
                if (j == 0) begin
                    p_rad  = i_rad[l];
                    p_rem  = '0;
                    p_root = '0;
                end else begin
                    p_rad  = r_rad[l][j-1];
                    p_rem  = r_rem[l][j-1];
                    p_root = r_root[l][j-1];
                end
                // Bring down the next two radicand bits and try root*4+1.
                cur   = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
                trial = {{(REM_W-RT_W-2){1'b0}}, p_root, 2'b01};
                n_rad[l][j] = p_rad << 2;
                if (cur >= trial) begin
                    n_rem[l][j]  = cur - trial;
                    n_root[l][j] = {p_root[RT_W-2:0], 1'b1};
                end else begin
                    n_rem[l][j]  = cur;
                    n_root[l][j] = {p_root[RT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < RT_W; j++) begin
            if (i_en[j]) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rad[l][j]  <= n_rad[l][j];
                    r_rem[l][j]  <= n_rem[l][j];
                    r_root[l][j] <= n_root[l][j];
                end
                r_tag[j] <= (j == 0) ? i_tag : r_tag[j-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_root[l] = r_root[l][RT_W-1];
        end
    end

    assign o_tag = r_tag[RT_W-1];

endmodule

// ===== hdl/sac_quot.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sac_quot
// Scales the half-angle sine by each axis component and divides by the
// axis length: one multiply stage, one rounding stage, then a restoring
// divider with one quotient bit per stage for the x and z lanes.
// ============================================================================
module sac_quot #(
    parameter int FRAC_BITS = sac_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic [FRAC_BITS+2:0]          i_en,
    input  logic [sac_pkg::LEN_W-1:0]     i_len,
    input  logic [FRAC_BITS:0]            i_w,
    input  logic [FRAC_BITS:0]            i_s,
    input  sac_pkg::t_front_tag           i_tag,
    output logic [FRAC_BITS:0]            o_mx,
    output logic [FRAC_BITS:0]            o_mz,
    output logic [FRAC_BITS:0]            o_w,
    output logic [FRAC_BITS:0]            o_s,
    output sac_pkg::t_front_tag           o_tag
);

    localparam int QW = FRAC_BITS + 1;
    localparam int LW = sac_pkg::LEN_W;
    localparam int PW = QW + sac_pkg::IN_W;
    localparam int NW = PW + sac_pkg::NUM_SHIFT + 2;

    // Product stage.
    logic [PW-1:0]        r_px, r_pz;
    logic [LW-1:0]        r_len_p;
    logic [QW-1:0]        r_w_p, r_s_p;
    sac_pkg::t_front_tag  r_tag_p;
    logic [PW-1:0]        n_px, n_pz;

    // Rounded numerator stage.
    logic [NW-1:0]        r_nx, r_nz;
    logic [LW-1:0]        r_len_n;
    logic [QW-1:0]        r_w_n, r_s_n;
    sac_pkg::t_front_tag  r_tag_n;
    logic [NW-1:0]        n_nx, n_nz;

    // Divider stages.
    logic [NW-1:0]        r_rx   [QW];
    logic [NW-1:0]        r_rz   [QW];
    logic [QW-1:0]        r_qx   [QW];
    logic [QW-1:0]        r_qz   [QW];
    logic [LW-1:0]        r_len_d[QW];
    logic [QW-1:0]        r_w_d  [QW];
    logic [QW-1:0]        r_s_d  [QW];
    sac_pkg::t_front_tag  r_tag_d[QW];
    logic [NW-1:0]        n_rx   [QW];
    logic [NW-1:0]        n_rz   [QW];
    logic [QW-1:0]        n_qx   [QW];
    logic [QW-1:0]        n_qz   [QW];

    always_comb begin
        n_px = PW'(i_tag.az) * PW'(i_s);
        n_pz = PW'(i_tag.ax) * PW'(i_s);
        // Adding half the divisor turns the truncating divide into rounding.
        n_nx = (NW'(r_px) << sac_pkg::NUM_SHIFT) + NW'(r_len_p >> 1);
        n_nz = (NW'(r_pz) << sac_pkg::NUM_SHIFT) + NW'(r_len_p >> 1);
    end

    always_comb begin
        logic [NW-1:0] p_rx, p_rz, dvs;
        logic [QW-1:0] p_qx, p_qz;
        logic [LW-1:0] p_len;
        int            b;
        for (int i = 0; i < QW; i++) begin
            if (i == 0) begin
                p_rx  = r_nx;
                p_rz  = r_nz;
                p_qx  = '0;
                p_qz  = '0;
                p_len = r_len_n;
            end else begin
                p_rx  = r_rx[i-1];
                p_rz  = r_rz[i-1];
                p_qx  = r_qx[i-1];
                p_qz  = r_qz[i-1];
                p_len = r_len_d[i-1];
            end
            b   = QW - 1 - i;
            dvs = NW'(p_len) << b;
            if (p_rx >= dvs) begin
                n_rx[i] = p_rx - dvs;
                n_qx[i] = p_qx | (QW'(1) << b);
            end else begin
                n_rx[i] = p_rx;
                n_qx[i] = p_qx;
            end
            if (p_rz >= dvs) begin
                n_rz[i] = p_rz - dvs;
                n_qz[i] = p_qz | (QW'(1) << b);
            end else begin
                n_rz[i] = p_rz;
                n_qz[i] = p_qz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_px    <= n_px;
            r_pz    <= n_pz;
            r_len_p <= i_len;
            r_w_p   <= i_w;
            r_s_p   <= i_s;
            r_tag_p <= i_tag;
        end
        if (i_en[1]) begin
            r_nx    <= n_nx;
            r_nz    <= n_nz;
            r_len_n <= r_len_p;
            r_w_n   <= r_w_p;
            r_s_n   <= r_s_p;
            r_tag_n <= r_tag_p;
        end
        for (int i = 0; i < QW; i++) begin
            if (i_en[i+2]) begin
                r_rx[i]    <= n_rx[i];
                r_rz[i]    <= n_rz[i];
                r_qx[i]    <= n_qx[i];
                r_qz[i]    <= n_qz[i];
                r_len_d[i] <= (i == 0) ? r_len_n : r_len_d[i-1];
                r_w_d[i]   <= (i == 0) ? r_w_n   : r_w_d[i-1];
                r_s_d[i]   <= (i == 0) ? r_s_n   : r_s_d[i-1];
                r_tag_d[i] <= (i == 0) ? r_tag_n : r_tag_d[i-1];
            end
        end
    end

    assign o_mx  = r_qx[QW-1];
    assign o_mz  = r_qz[QW-1];
    assign o_w   = r_w_d[QW-1];
    assign o_s   = r_s_d[QW-1];
    assign o_tag = r_tag_d[QW-1];

endmodule

// ===== hdl/sac_final.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sac_final
// Output stage: picks the quaternion for the case taken, applies the signs
// and saturates every part to the 16-bit result range.
// ============================================================================
module sac_final #(
    parameter int FRAC_BITS = sac_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [FRAC_BITS:0]                 i_mx,
    input  logic [FRAC_BITS:0]                 i_mz,
    input  logic [FRAC_BITS:0]                 i_w,
    input  logic [FRAC_BITS:0]                 i_s,
    input  sac_pkg::t_front_tag                i_tag,
    output logic signed [sac_pkg::OUT_W-1:0]   o_quat_w,
    output logic signed [sac_pkg::OUT_W-1:0]   o_quat_x,
    output logic signed [sac_pkg::OUT_W-1:0]   o_quat_y,
    output logic signed [sac_pkg::OUT_W-1:0]   o_quat_z,
    output logic [sac_pkg::CASE_W-1:0]         o_case
);

    localparam int OW = sac_pkg::OUT_W;
    localparam int QW = FRAC_BITS + 1;
    localparam int SX = (FRAC_BITS + 2 > OW + 1) ? FRAC_BITS + 2 : OW + 1;
    localparam logic signed [SX-1:0] ONE = SX'(1) << FRAC_BITS;

    function automatic logic signed [OW-1:0] sat(input logic signed [SX-1:0] v);
        logic signed [SX-1:0] hi, lo;
        hi = $signed({{(SX-OW+1){1'b0}}, {(OW-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return hi[OW-1:0];
        end else if (v < lo) begin
            return lo[OW-1:0];
        end
        return v[OW-1:0];
    endfunction

    logic signed [SX-1:0]       w_w, w_x, w_z, w_mx, w_mz;
    logic signed [OW-1:0]       r_qw, r_qx, r_qy, r_qz;
    logic [sac_pkg::CASE_W-1:0] r_case;

    assign w_mx = $signed({{(SX-QW){1'b0}}, i_mx});
    assign w_mz = $signed({{(SX-QW){1'b0}}, i_mz});

    always_comb begin
        case (i_tag.kind)
            sac_pkg::CASE_ALIGNED: begin
                w_w = ONE;
                w_x = '0;
                w_z = '0;
            end
            sac_pkg::CASE_INVERTED: begin
                w_w = '0;
                w_x = ONE;
                w_z = '0;
            end
            default: begin
                w_w = $signed({{(SX-QW){1'b0}}, i_w});
                // A zero-length axis falls back to a rotation about +X.
                if (i_tag.axis_zero) begin
                    w_x = $signed({{(SX-QW){1'b0}}, i_s});
                    w_z = '0;
                end else begin
                    w_x = i_tag.neg_x ? -w_mx : w_mx;
                    w_z = i_tag.neg_z ? -w_mz : w_mz;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qw   <= sat(w_w);
            r_qx   <= sat(w_x);
            r_qy   <= '0;
            r_qz   <= sat(w_z);
            r_case <= i_tag.kind;
        end
    end

    assign o_quat_w = r_qw;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;
    assign o_case   = r_case;

endmodule

// ===== hdl/shortest_arc_quat_from_up.sv =====
`timescale 1ns / 1ps
// ============================================================================
// shortest_arc_quat_from_up
// Quaternion that turns +Y onto a signed fixed-point surface normal.
// ============================================================================
// Usage:
// Normals enter on i_norm, one per transfer; results leave on o_quat with
// the quaternion (w, x, y, z) and a case code. Every normal yields exactly
// one result, in order.
// The block is a FRAC_BITS + 39 stage pipeline: three front stages, 32
// stages of a bit-serial square root that computes the two half-angle terms
// and the axis length side by side, FRAC_BITS + 3 stages of scaling and
// bit-per-stage division, and the output register. One normal is taken per
// clock cycle while o_quat is not stalled or some stage is empty.
// Each stage holds a valid bit. When o_quat is stalled, a stage moves only
// into an empty stage after it, so items pack up behind the output and
// i_norm.ready falls only once every stage is full; nothing is dropped.
// The alignment threshold is written through i_cfg_we / i_cfg_data and
// should only change while the pipeline is empty.
// Reset (synchronous, active low) empties the pipeline and restores the
// threshold to its default; the data registers keep their contents.
// ============================================================================
module shortest_arc_quat_from_up #(
    parameter int FRAC_BITS = sac_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sac_in_if.sink                      i_norm,
    sac_out_if.source                   o_quat,
    input  logic                        i_cfg_we,
    input  logic [sac_pkg::THR_W-1:0]   i_cfg_data
);

    localparam int FR_ST  = sac_pkg::FRONT_STAGES;
    localparam int SQ_ST  = sac_pkg::SQRT_RAD_W / 2;
    localparam int DV_ST  = FRAC_BITS + 3;
    localparam int NST    = FR_ST + SQ_ST + DV_ST + 1;
    localparam int QW     = FRAC_BITS + 1;
    localparam int LANE_W = 0;
    localparam int LANE_S = 1;
    localparam int LANE_L = 2;
    localparam int LANES  = 3;

    logic [sac_pkg::THR_W-1:0]   r_thr;
    logic [NST-1:0]              r_valid;
    logic [NST-1:0]              n_valid;
    logic [NST-1:0]              w_en;

    logic [sac_pkg::SQRT_RAD_W-1:0]    w_rad  [LANES];
    logic [sac_pkg::SQRT_RAD_W/2-1:0]  w_root [LANES];
    sac_pkg::t_front_tag               w_tag_f, w_tag_r, w_tag_q;
    logic [QW-1:0]                     w_mx, w_mz, w_w, w_s;

    // A stage may load when the output is taken or some stage at or after it
    // is empty.
    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_en
            assign w_en[k] = o_quat.ready || !(&r_valid[NST-1:k]);
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < NST; i++) begin
            if (!w_en[i]) begin
                n_valid[i] = r_valid[i];
            end else if (i == 0) begin
                n_valid[i] = i_norm.valid;
            end else begin
                n_valid[i] = r_valid[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_thr   <= sac_pkg::THR_RESET;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    assign i_norm.ready = w_en[0];
    assign o_quat.valid = r_valid[NST-1];

    sac_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_en      (w_en[FR_ST-1:0]),
        .i_nx      (i_norm.normal_x),
        .i_ny      (i_norm.normal_y),
        .i_nz      (i_norm.normal_z),
        .i_thr     (r_thr),
        .o_rad_w   (w_rad[LANE_W]),
        .o_rad_s   (w_rad[LANE_S]),
        .o_rad_len (w_rad[LANE_L]),
        .o_tag     (w_tag_f)
    );

    sac_isqrt_pipe #(.LANES(LANES)) u_root (
        .i_clk  (i_clk),
        .i_en   (w_en[FR_ST+SQ_ST-1:FR_ST]),
        .i_rad  (w_rad),
        .i_tag  (w_tag_f),
        .o_root (w_root),
        .o_tag  (w_tag_r)
    );

    sac_quot #(.FRAC_BITS(FRAC_BITS)) u_quot (
        .i_clk  (i_clk),
        .i_en   (w_en[FR_ST+SQ_ST+DV_ST-1:FR_ST+SQ_ST]),
        .i_len  (w_root[LANE_L]),
        .i_w    (w_root[LANE_W][QW-1:0]),
        .i_s    (w_root[LANE_S][QW-1:0]),
        .i_tag  (w_tag_r),
        .o_mx   (w_mx),
        .o_mz   (w_mz),
        .o_w    (w_w),
        .o_s    (w_s),
        .o_tag  (w_tag_q)
    );

    sac_final #(.FRAC_BITS(FRAC_BITS)) u_final (
        .i_clk    (i_clk),
        .i_en     (w_en[NST-1]),
        .i_mx     (w_mx),
        .i_mz     (w_mz),
        .i_w      (w_w),
        .i_s      (w_s),
        .i_tag    (w_tag_q),
        .o_quat_w (o_quat.quat_w),
        .o_quat_x (o_quat.quat_x),
        .o_quat_y (o_quat.quat_y),
        .o_quat_z (o_quat.quat_z),
        .o_case   (o_quat.case_taken)
    );

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_quat.valid)
        else $error("result valid right after reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_valid) && !o_quat.ready) |-> !i_norm.ready)
        else $error("input taken while every stage is full and stalled");

    a_y_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> (o_quat.quat_y == '0))
        else $error("nonzero y part in result");

    a_w_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> !o_quat.quat_w[sac_pkg::OUT_W-1])
        else $error("negative scalar part in result");

    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_quat.valid && (o_quat.case_taken == sac_pkg::CASE_ALIGNED))
        |-> (o_quat.quat_x == '0) && (o_quat.quat_z == '0) && (o_quat.quat_w != '0))
        else $error("aligned case without identity result");
`endif

endmodule
